FILE: rtl/mpr_pkg.sv
// Shared constants, types and state encoding for the median pivot selector.
package mpr_pkg;

  localparam int MAX_ELEMS   = 64;
  localparam int IDX_W       = $clog2(MAX_ELEMS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int VAL_W       = 32;
  localparam int RANK_W      = 6;
  localparam int OUT_TDATA_W = ((VAL_W + RANK_W + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_GRAB,
    ST_SCAN,
    ST_EVAL,
    ST_OUT
  } state_t;

  // Controls from the sequencer to the rank unit
  typedef struct packed {
    logic cand_load;  // capture candidate from read data, clear lower count
    logic cmp_en;     // read data is valid: compare against candidate
    logic best_upd;   // evaluate the candidate's gap against the best so far
    logic first;      // candidate is the first element of the set
  } rank_ctl_t;

endpackage

FILE: rtl/median_pivot_by_rank.sv
// Top level: load sequencer, rank-selection sequencer and stream handshakes.
//
// Usage: elements arrive on the in_ channel, one signed 32-bit value per
// transaction, and in_tlast marks the final element of a set. Up to 64
// elements are stored; later ones are dropped and flagged as overflow.
// Loading accepts an element on every cycle with in_tvalid high, as in_tready stays high while loading.
// After the last element the block drops in_tready and ranks every stored
// element with one shared comparator: each candidate in turn is fetched,
// captured, compared against all stored elements through the single
// store read port and the single comparator, and evaluated. The result then
// appears on the out_ channel as one transaction and is held until
// out_tready is high; no new element is taken until it is delivered. Reset
// (rst_n low, synchronous) empties the set, clears the overflow flag and
// returns to loading. The store contents are not cleared; only elements of
// the current set are ever read.
module median_pivot_by_rank (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mpr_pkg::VAL_W-1:0]           in_tdata,   // [31:0] sample_value
  input  logic                                in_tlast,   // is_last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mpr_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] pivot_value,
                                                          // [37:32] pivot_rank, rest 0
  output logic                                out_tuser   // [0] overflow
);
  import mpr_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              ovf_r;
  logic              ovf_nxt;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  i_nxt;
  logic [CNT_W-1:0]  j_r;
  logic [CNT_W-1:0]  j_nxt;
  logic              rd_valid_r;
  logic              rd_issue;
  logic              in_acc;
  logic              out_acc;
  logic              store_we;
  logic [IDX_W-1:0]  raddr;
  logic [VAL_W-1:0]  rd_data;
  logic [VAL_W-1:0]  pivot_value;
  logic [RANK_W-1:0] pivot_rank;
  logic              last_cand;
  rank_ctl_t         rank_ctl;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign store_we  = in_acc && (count_r < CNT_W'(MAX_ELEMS));
  assign last_cand = (i_r + CNT_W'(1)) == count_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (in_acc && in_tlast) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_GRAB;
      ST_GRAB:  state_nxt = ST_SCAN;
      ST_SCAN:  if (j_r == count_r) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = last_cand ? ST_OUT : ST_FETCH;
      ST_OUT:   if (out_acc) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Outputs and counter updates
  always_comb begin
    in_tready          = 1'b0;
    out_tvalid         = 1'b0;
    rd_issue           = 1'b0;
    raddr              = i_r[IDX_W-1:0];
    count_nxt          = count_r;
    ovf_nxt            = ovf_r;
    i_nxt              = i_r;
    j_nxt              = j_r;
    rank_ctl.cand_load = 1'b0;
    rank_ctl.cmp_en    = rd_valid_r;
    rank_ctl.best_upd  = 1'b0;
    rank_ctl.first     = (i_r == '0);
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        i_nxt     = '0;
        if (store_we) begin
          count_nxt = count_r + CNT_W'(1);
        end else if (in_acc) begin
          ovf_nxt = 1'b1;
        end
      end
      ST_FETCH: begin
        raddr = i_r[IDX_W-1:0];
      end
      ST_GRAB: begin
        rank_ctl.cand_load = 1'b1;
        j_nxt              = '0;
      end
      ST_SCAN: begin
        raddr = j_r[IDX_W-1:0];
        if (j_r < count_r) begin
          rd_issue = 1'b1;
          j_nxt    = j_r + CNT_W'(1);
        end
      end
      ST_EVAL: begin
        rank_ctl.best_upd = 1'b1;
        i_nxt             = i_r + CNT_W'(1);
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_acc) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      rd_valid_r <= rd_issue;
    end
  end

  mpr_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_tdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  mpr_rank u_rank (
    .clk         (clk),
    .ctl         (rank_ctl),
    .rd_data     (rd_data),
    .elem_cnt    (count_r),
    .pivot_value (pivot_value),
    .pivot_rank  (pivot_rank)
  );

  // Result transaction
  assign out_tdata = {(OUT_TDATA_W - VAL_W - RANK_W)'(0), pivot_rank, pivot_value};
  assign out_tuser = ovf_r;

`ifndef ASSERT_OFF
  // Loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // Element count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMS))
    else $error("element count beyond store depth");

  // Overflow only with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CNT_W'(MAX_ELEMS)))
    else $error("overflow without full store");

  // A final element starts the selection
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == ST_FETCH))
    else $error("selection not started after last element");

  // Scan index stays within the set, and the set is never empty while ranking
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((j_r <= count_r) && (count_r != '0)))
    else $error("scan index out of range");
`endif

endmodule

FILE: rtl/mpr_store.sv
// Element store: one write port, one read port with registered read data.
module mpr_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [mpr_pkg::IDX_W-1:0]     waddr,
  input  logic [mpr_pkg::VAL_W-1:0]     wdata,
  input  logic [mpr_pkg::IDX_W-1:0]     raddr,
  output logic [mpr_pkg::VAL_W-1:0]     rdata
);
  import mpr_pkg::*;

  logic [VAL_W-1:0] mem [MAX_ELEMS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mpr_rank.sv
// Shared signed comparator with lower-rank counter, gap calculation and best tracking.
module mpr_rank (
  input  logic                          clk,
  input  mpr_pkg::rank_ctl_t            ctl,
  input  logic [mpr_pkg::VAL_W-1:0]     rd_data,
  input  logic [mpr_pkg::CNT_W-1:0]     elem_cnt,
  output logic [mpr_pkg::VAL_W-1:0]     pivot_value,
  output logic [mpr_pkg::RANK_W-1:0]    pivot_rank
);
  import mpr_pkg::*;

  logic [VAL_W-1:0]  cand_r;
  logic [CNT_W-1:0]  lower_r;
  logic [CNT_W-1:0]  lower_nxt;
  logic [CNT_W-1:0]  upper;
  logic [CNT_W-1:0]  gap;
  logic [CNT_W-1:0]  best_gap_r;
  logic [VAL_W-1:0]  best_value_r;
  logic [RANK_W-1:0] best_rank_r;
  logic              is_less;
  logic              take;

  // The one comparator: stored element strictly below the candidate
  assign is_less = $signed(rd_data) < $signed(cand_r);

  always_comb begin
    lower_nxt = lower_r;
    if (ctl.cand_load) begin
      lower_nxt = '0;
    end else if (ctl.cmp_en && is_less) begin
      lower_nxt = lower_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cand_load) begin
      cand_r <= rd_data;
    end
    lower_r <= lower_nxt;
  end

  // Upper rank and the distance between the two ranks
  always_comb begin
    upper = elem_cnt - lower_r - CNT_W'(1);
    if (upper >= lower_r) begin
      gap = upper - lower_r;
    end else begin
      gap = lower_r - upper;
    end
  end

  // Earliest element with the strictly smallest gap wins
  assign take = ctl.best_upd && (ctl.first || (gap < best_gap_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_gap_r   <= gap;
      best_value_r <= cand_r;
      best_rank_r  <= lower_r[RANK_W-1:0];
    end
  end

  assign pivot_value = best_value_r;
  assign pivot_rank  = best_rank_r;

`ifndef ASSERT_OFF
  // Lower rank can never reach the element count
  a_lower_bound: assert property (@(posedge clk)
    ctl.best_upd |-> (lower_r < elem_cnt))
    else $error("lower rank not below element count");

  // Loading a candidate restarts the count
  a_lower_clear: assert property (@(posedge clk)
    ctl.cand_load |=> (lower_r == '0))
    else $error("lower rank not cleared on candidate load");

  // A fresh set always takes its first candidate
  a_first_take: assert property (@(posedge clk)
    (ctl.best_upd && ctl.first) |=> (best_gap_r == $past(gap)))
    else $error("first candidate not taken");
`endif

endmodule
